[hdl/blake2b_hash_engine_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef BLAKE2B_HASH_ENGINE_CORE_DEFINES_SVH
`define BLAKE2B_HASH_ENGINE_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define B2B_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define B2B_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/b2b_pkg.sv]
//------------------------------------------------------------------------------
// b2b_pkg
// Types and constants for the BLAKE2b hash engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2b_pkg;

    localparam int NumRounds = 12;
    localparam logic [63:0] ParamWord = 64'h0000_0000_0101_0040;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_COMP,
        S_FINISH,
        S_EMIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic       put_byte;
        logic       pad;
        logic       comp_start;
        logic       comp_step;
        logic       comp_final;
        logic       comp_done;
        logic       reinit;
        logic [2:0] out_index;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic need_comp;
        logic need_final_pad;
    } t_status;

    function automatic logic [63:0] iv_word(input logic [2:0] idx);
        logic [63:0] r;
        begin
            unique case (idx)
                3'd0: r = 64'h6a09e667f3bcc908;
                3'd1: r = 64'hbb67ae8584caa73b;
                3'd2: r = 64'h3c6ef372fe94f82b;
                3'd3: r = 64'ha54ff53a5f1d36f1;
                3'd4: r = 64'h510e527fade682d1;
                3'd5: r = 64'h9b05688c2b3e6c1f;
                3'd6: r = 64'h1f83d9abfb41bd6b;
                default: r = 64'h5be0cd19137e2179;
            endcase
            return r;
        end
    endfunction

    // Message word index for round (mod 10) and position 0..15.
    function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] pos);
        logic [63:0] row;
        begin
            case (rnd)
                4'd0: row = 64'hfedcba9876543210;
                4'd1: row = 64'h357b20c16df984ae;
                4'd2: row = 64'h491763eadf250c8b;
                4'd3: row = 64'h8f04a562ebcd1397;
                4'd4: row = 64'hd386cb1efa427509;
                4'd5: row = 64'h91ef57d438b0a6c2;
                4'd6: row = 64'hb8293670a4def15c;
                4'd7: row = 64'ha2684f05931ce7bd;
                4'd8: row = 64'h5a417d2c803b9ef6;
                default: row = 64'h0dc3e9bf5167482a;
            endcase
            return row[{pos, 2'b00} +: 4];
        end
    endfunction

endpackage

[hdl/b2b_ctrl.sv]
//------------------------------------------------------------------------------
// b2b_ctrl
// Sequencer: byte absorb, 12-round compression in half-G steps, emit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2b_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_has_byte,
    input  logic             i_end_of_message,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_last,
    input  b2b_pkg::t_status i_status,
    output b2b_pkg::t_cmd    o_cmd
);
    import b2b_pkg::*;

    localparam logic [5:0] CompDoneStep = 6'(4 * NumRounds + 1);

    t_state     r_state, n_state;
    logic [5:0] r_step, n_step;
    logic [2:0] r_idx, n_idx;
    logic       r_has, n_has, r_end, n_end, r_final, n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_has   <= 1'b0;
            r_end   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_has   <= n_has;
            r_end   <= n_end;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_has   = r_has;
        n_end   = r_end;
        n_final = r_final;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_has   = i_has_byte;
                    n_end   = i_end_of_message;
                    n_final = 1'b0;
                    n_step  = '0;
                    if (i_has_byte && i_status.need_comp) begin
                        n_state = S_COMP;
                    end else if (i_has_byte) begin
                        n_state = S_ABSORB;
                    end else if (i_end_of_message) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_ABSORB: begin
                n_has = 1'b0;
                n_state = r_end ? S_FINISH : S_IDLE;
            end
            S_COMP: begin
                n_step = r_step + 6'd1;
                if (r_step == CompDoneStep) begin
                    n_step = '0;
                    if (r_final) begin
                        n_idx   = '0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_ABSORB;
                    end
                end
            end
            S_FINISH: begin
                n_final = 1'b1;
                n_step  = '0;
                n_state = S_COMP;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_EMIT);
        o_last = (r_idx == 3'd7);
        o_cmd = '0;
        o_cmd.out_index = r_idx;
        unique case (r_state)
            S_ABSORB: o_cmd.put_byte = r_has;
            S_COMP: begin
                o_cmd.comp_start = (r_step == 6'd0);
                o_cmd.comp_step  = (r_step != 6'd0) && (r_step != CompDoneStep);
                o_cmd.comp_done  = (r_step == CompDoneStep);
                o_cmd.comp_final = r_final;
            end
            S_FINISH: o_cmd.pad = i_status.need_final_pad;
            S_EMIT: o_cmd.reinit = i_out_ready && (r_idx == 3'd7);
            default: ;
        endcase
    end

endmodule

[hdl/b2b_datapath.sv]
//------------------------------------------------------------------------------
// b2b_datapath
// Chain, counter, block buffer and a four-lane G half-step unit.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2b_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_accept,
    input  logic [7:0]       i_data_byte,
    input  b2b_pkg::t_cmd    i_cmd,
    output b2b_pkg::t_status o_status,
    output logic [63:0]      o_digest_word
);
    import b2b_pkg::*;

    logic [63:0] r_h [8];
    logic [63:0] r_m [16];
    logic [63:0] r_v [16];
    logic [63:0] r_cnt;
    logic [7:0]  r_byte;
    logic [6:0]  w_pos;

    assign w_pos = r_cnt[6:0];
    assign o_status.need_comp = (w_pos == 7'd0) && (r_cnt != 64'd0);
    assign o_status.need_final_pad = (w_pos != 7'd0) || (r_cnt == 64'd0);
    assign o_digest_word = r_h[i_cmd.out_index];

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Phase: bits 5:2 round, bit 1 diagonal, bit 0 second half of G.
    logic [5:0]  r_ph;
    logic [3:0]  w_rnd;
    logic [63:0] w_x [4];
    logic [3:0]  w_ia2 [4], w_ib2 [4], w_ic2 [4], w_id2 [4];
    logic [63:0] w_na [4], w_nb [4], w_nc [4], w_nd [4];

    always_comb begin
        w_rnd = (r_ph[5:2] >= 4'd10) ? r_ph[5:2] - 4'd10 : r_ph[5:2];
        for (int j = 0; j < 4; j++) begin
            w_ia2[j] = 4'(j);
            w_ib2[j] = r_ph[1] ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
            w_ic2[j] = r_ph[1] ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
            w_id2[j] = r_ph[1] ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
            w_x[j] = r_m[sigma(w_rnd, {r_ph[1], 2'(j), r_ph[0]})];
        end
        for (int j = 0; j < 4; j++) begin
            w_na[j] = r_v[w_ia2[j]] + r_v[w_ib2[j]] + w_x[j];
            w_nd[j] = rotr(r_v[w_id2[j]] ^ w_na[j], r_ph[0] ? 16 : 32);
            w_nc[j] = r_v[w_ic2[j]] + w_nd[j];
            w_nb[j] = rotr(r_v[w_ib2[j]] ^ w_nc[j], r_ph[0] ? 63 : 24);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ph  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= (i == 0) ? (iv_word(3'(i)) ^ ParamWord) : iv_word(3'(i));
            end
        end else begin
            if (i_in_accept) begin
                r_byte <= i_data_byte;
            end
            if (i_cmd.put_byte) begin
                r_m[w_pos[6:3]][{w_pos[2:0], 3'b000} +: 8] <= r_byte;
                r_cnt <= r_cnt + 64'd1;
            end
            if (i_cmd.pad) begin
                for (int k = 0; k < 128; k++) begin
                    if (7'(k) >= w_pos) begin
                        r_m[k / 8][(k % 8) * 8 +: 8] <= 8'h00;
                    end
                end
            end
            if (i_cmd.comp_start) begin
                r_ph <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i]     <= r_h[i];
                    r_v[i + 8] <= iv_word(3'(i));
                end
                r_v[12] <= iv_word(3'd4) ^ r_cnt;
                r_v[14] <= iv_word(3'd6) ^ {64{i_cmd.comp_final}};
            end else if (i_cmd.comp_step) begin
                r_ph <= r_ph + 6'd1;
                for (int j = 0; j < 4; j++) begin
                    r_v[w_ia2[j]] <= w_na[j];
                    r_v[w_ib2[j]] <= w_nb[j];
                    r_v[w_ic2[j]] <= w_nc[j];
                    r_v[w_id2[j]] <= w_nd[j];
                end
            end
            if (i_cmd.comp_done) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                end
            end
            if (i_cmd.reinit) begin
                r_cnt <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= (i == 0) ? (iv_word(3'(i)) ^ ParamWord) : iv_word(3'(i));
                end
            end
        end
    end

endmodule

[hdl/blake2b_hash_engine_core.sv]
// A byte item is absorbed in S_ABSORB; a byte that starts a new block first runs a compression.
// End of message: pads, runs the final compression, then emits one word per cycle while i_out_ready is high.
// The engine takes one item at a time; compression is a load, 48 half-G steps and a fold.
// Reset (i_rst_n low, synchronous) loads the initial chain and clears the byte count.
//------------------------------------------------------------------------------
// blake2b_hash_engine_core
// Unkeyed BLAKE2b-512 over a byte stream; emits eight digest words.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module blake2b_hash_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import b2b_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    b2b_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_has_byte(i_has_byte), .i_end_of_message(i_end_of_message),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_last(o_last_word), .i_status(w_status), .o_cmd(w_cmd)
    );

    b2b_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_accept(i_in_valid && o_in_ready), .i_data_byte(i_data_byte),
        .i_cmd(w_cmd), .o_status(w_status), .o_digest_word(o_digest_word)
    );

    assign o_word_index = w_cmd.out_index;

endmodule

[hdl/b2b_checker.sv]
//------------------------------------------------------------------------------
// b2b_checker
// Port-level checks for the BLAKE2b hash engine.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "blake2b_hash_engine_core_defines.svh"

module b2b_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_word_index,
    input logic       o_last_word
);
    `B2B_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "ready during emit")
    `B2B_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_out_valid, o_last_word == (o_word_index == 3'd7), "last flag")
    `B2B_ASSERT_NEXT(a_idx_adv, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last_word, o_out_valid && o_word_index == $past(o_word_index) + 3'd1, "index step")
    `B2B_ASSERT_NEXT(a_end_emit, i_clk, i_rst_n, o_out_valid && i_out_ready && o_last_word, !o_out_valid, "emit end")
endmodule

bind blake2b_hash_engine_core b2b_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_word_index(o_word_index), .o_last_word(o_last_word)
);

[bench/blake2b_hash_engine_core_test.sv]
//------------------------------------------------------------------------------
// blake2b_hash_engine_core_test
// Streams byte items into the BLAKE2b-512 engine and compares every digest
// word with an in-bench BLAKE2b model, under random gaps and output stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module blake2b_hash_engine_core_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_has_byte = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    localparam int WatchdogLimit = 20000;

    t_digest_word digest_queue[$];
    logic [63:0]  chain[8];
    logic [63:0]  msg_bytes;
    logic [63:0]  block[16];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           hold_output = 1'b0;

    blake2b_hash_engine_core dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] iv(input int k);
        logic [63:0] t[8] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
                              64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
                              64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
                              64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
        return t[k];
    endfunction

    function automatic int perm(input int r, input int p);
        int s[10][16] = '{
            '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
            '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
            '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
            '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
            '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
            '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
            '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
            '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
            '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
            '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
        return s[r % 10][p];
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    task automatic quarter(inout logic [63:0] v[16], input int a, input int b,
                           input int c, input int d, input logic [63:0] x,
                           input logic [63:0] y);
        v[a] = v[a] + v[b] + x;
        v[d] = ror(v[d] ^ v[a], 32);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 24);
        v[a] = v[a] + v[b] + y;
        v[d] = ror(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = ror(v[b] ^ v[c], 63);
    endtask

    task automatic compress_block(input bit final_block);
        logic [63:0] v[16];
        for (int k = 0; k < 8; k++) begin
            v[k] = chain[k];
            v[k + 8] = iv(k);
        end
        v[12] ^= msg_bytes;
        if (final_block) v[14] = ~v[14];
        for (int r = 0; r < 12; r++) begin
            quarter(v, 0, 4, 8, 12, block[perm(r, 0)], block[perm(r, 1)]);
            quarter(v, 1, 5, 9, 13, block[perm(r, 2)], block[perm(r, 3)]);
            quarter(v, 2, 6, 10, 14, block[perm(r, 4)], block[perm(r, 5)]);
            quarter(v, 3, 7, 11, 15, block[perm(r, 6)], block[perm(r, 7)]);
            quarter(v, 0, 5, 10, 15, block[perm(r, 8)], block[perm(r, 9)]);
            quarter(v, 1, 6, 11, 12, block[perm(r, 10)], block[perm(r, 11)]);
            quarter(v, 2, 7, 8, 13, block[perm(r, 12)], block[perm(r, 13)]);
            quarter(v, 3, 4, 9, 14, block[perm(r, 14)], block[perm(r, 15)]);
        end
        for (int k = 0; k < 8; k++) chain[k] ^= v[k] ^ v[k + 8];
    endtask

    task automatic restart_chain();
        for (int k = 0; k < 8; k++) chain[k] = iv(k);
        chain[0] ^= 64'h0101_0040;
        msg_bytes = '0;
    endtask

    task automatic predict_digest(input logic [7:0] b, input bit has_b, input bit eom);
        int pos;
        if (has_b) begin
            pos = int'(msg_bytes[6:0]);
            if (pos == 0 && msg_bytes != 0) compress_block(1'b0);
            block[pos / 8][(pos % 8) * 8 +: 8] = b;
            msg_bytes++;
        end
        if (eom) begin
            pos = int'(msg_bytes[6:0]);
            if (pos != 0 || msg_bytes == 0)
                for (int k = pos; k < 128; k++) block[k / 8][(k % 8) * 8 +: 8] = 8'h00;
            compress_block(1'b1);
            for (int k = 0; k < 8; k++) digest_queue.push_back({chain[k], 3'(k), k == 7});
            restart_chain();
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic [7:0] b, input bit has_b, input bit eom);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_has_byte <= has_b;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_digest(b, has_b, eom);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit tail_byte);
        for (int k = 0; k < len; k++) send_item(8'($urandom), 1'b1, 1'b0);
        send_item(8'($urandom), tail_byte, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_queue.size() == 0) begin
                report("unexpected word", o_digest_word, 64'd0);
            end else begin
                t_digest_word w;
                w = digest_queue.pop_front();
                if (o_digest_word !== w.word) report("digest_word", o_digest_word, w.word);
                if (o_word_index !== w.index)
                    report("word_index", 64'(o_word_index), 64'(w.index));
                if (o_last_word !== w.last)
                    report("last_word", 64'(o_last_word), 64'(w.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_output) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_edge_cases();
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
        send_message(128, 1'b1);
    endtask

    task automatic test_output_stall();
        hold_output = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_output = 1'b0;
            end
            begin
                send_message(2, 1'b1);
                send_message(0, 1'b1);
                send_message(1, 1'b0);
            end
        join
    endtask

    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 12) begin
            int len;
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
                send_item(8'($urandom), 1'b1, 1'b0);
            end
            send_item(8'($urandom), $urandom_range(0, 1), 1'b1);
            sent += len + 1;
        end
    endtask

    initial begin
        restart_chain();
        for (int k = 0; k < 16; k++) block[k] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_cases();
        test_output_stall();
        test_random_messages();
        i_in_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/b2b_pkg.sv
hdl/b2b_ctrl.sv
hdl/b2b_datapath.sv
hdl/blake2b_hash_engine_core.sv
hdl/b2b_checker.sv
bench/blake2b_hash_engine_core_test.sv
